/* sv/cst_pkg.sv */
// cst_pkg: shared types, constants and keyword tables of the c-subset tokenizer
// used by every module of the block but cst_checker, no dependencies
`default_nettype none
package cst_pkg;

    localparam int TEXT_MAX = 63;
    localparam int LEN_W    = $clog2(TEXT_MAX + 1);
    localparam int MAX_RES  = 4;
    localparam int QDEPTH   = 4;
    localparam int NUM_KW   = 7;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_ZERO, M_DEC, M_HEX, M_STR, M_STR_ESC,
        M_CHR0, M_CHR_ESC, M_CHR_CLOSE, M_IDENT, M_OPEQ
    } t_mode;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_INT     = 5'd1;
    localparam logic [4:0] K_STRING  = 5'd2;
    localparam logic [4:0] K_ID      = 5'd3;
    localparam logic [4:0] K_PLUS    = 5'd4;
    localparam logic [4:0] K_MINUS   = 5'd5;
    localparam logic [4:0] K_STAR    = 5'd6;
    localparam logic [4:0] K_SLASH   = 5'd7;
    localparam logic [4:0] K_ASSIGN  = 5'd8;
    localparam logic [4:0] K_LPAREN  = 5'd9;
    localparam logic [4:0] K_RPAREN  = 5'd10;
    localparam logic [4:0] K_LBRACK  = 5'd11;
    localparam logic [4:0] K_RBRACK  = 5'd12;
    localparam logic [4:0] K_LBRACE  = 5'd13;
    localparam logic [4:0] K_RBRACE  = 5'd14;
    localparam logic [4:0] K_SEMI    = 5'd15;
    localparam logic [4:0] K_COMMA   = 5'd16;
    localparam logic [4:0] K_EQ      = 5'd17;
    localparam logic [4:0] K_NE      = 5'd18;
    localparam logic [4:0] K_LT      = 5'd19;
    localparam logic [4:0] K_GT      = 5'd20;
    localparam logic [4:0] K_LE      = 5'd21;
    localparam logic [4:0] K_GE      = 5'd22;
    localparam logic [4:0] K_KW_BASE = 5'd23;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_BAD_HEX   = 3'd1;
    localparam logic [2:0] E_LONE_BANG = 3'd2;
    localparam logic [2:0] E_UNKNOWN   = 3'd3;
    localparam logic [2:0] E_UNCLOSED  = 3'd4;

    typedef struct packed {
        logic        is_text;
        logic [7:0]  text_char;
        logic [4:0]  token_kind;
        logic [31:0] token_value;
        logic [5:0]  text_length;
        logic [2:0]  error_code;
    } t_res;

    typedef struct packed {
        logic [2:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [2:0] kw_len(input int k);
        case (k)
            0:       return 3'd2;
            1:       return 3'd4;
            2:       return 3'd5;
            3:       return 3'd3;
            default: return 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [39:0] s;
        s = 40'h0;
        case (k)
            0:       s = {8'h0, 8'h0, 8'h0, "f", "i"};
            1:       s = {8'h0, "e", "s", "l", "e"};
            2:       s = {"e", "l", "i", "h", "w"};
            3:       s = {8'h0, 8'h0, "t", "n", "i"};
            4:       s = {8'h0, "r", "a", "h", "c"};
            5:       s = {8'h0, "d", "i", "o", "v"};
            default: s = {8'h0, "n", "i", "a", "m"};
        endcase
        case (p)
            3'd0:    return s[7:0];
            3'd1:    return s[15:8];
            3'd2:    return s[23:16];
            3'd3:    return s[31:24];
            3'd4:    return s[39:32];
            default: return 8'h0;
        endcase
    endfunction

    function automatic logic [NUM_KW-1:0] kw_mask(input logic [NUM_KW-1:0] kc,
                                                  input logic [LEN_W-1:0] p,
                                                  input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        m = kc;
        for (int k = 0; k < NUM_KW; k++) begin
            if (p >= LEN_W'(kw_len(k)) || kw_char(k, p[2:0]) != c) m[k] = 1'b0;
        end
        return m;
    endfunction

    function automatic t_bundle push(input t_bundle bd, input logic t, input logic [7:0] c,
                                     input logic [4:0] k, input logic [31:0] v,
                                     input logic [5:0] l, input logic [2:0] e);
        t_bundle b;
        b = bd;
        if (b.cnt < 3'(MAX_RES)) begin
            b.res[b.cnt[1:0]] = '{is_text: t, text_char: c, token_kind: k,
                                  token_value: v, text_length: l, error_code: e};
            b.cnt = b.cnt + 3'd1;
        end
        return b;
    endfunction

endpackage
`default_nettype wire

/* sv/cst_front.sv */
// cst_front: scanner state machine, classifies each source byte into a bundle of results
// depends on cst_pkg
`default_nettype none
module cst_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_present,
    input  wire logic              i_eos,
    output cst_pkg::t_bundle       o_bundle,
    output logic                   o_push
);
    cst_pkg::t_mode                     r_mode, n_mode;
    logic [31:0]                        r_acc, n_acc;
    logic [7:0]                         r_held, n_held;
    logic [cst_pkg::LEN_W-1:0]          r_len, n_len;
    logic [cst_pkg::NUM_KW-1:0]         r_kc, n_kc;
    logic                               r_ds, n_ds;
    logic                               r_eh, n_eh;
    cst_pkg::t_bundle                   bd;

    always_comb begin
        logic restart;
        logic [7:0] b;
        logic [4:0] kind;
        logic [3:0] hv;
        logic hok;
        b = i_byte;
        n_mode = r_mode; n_acc = r_acc; n_held = r_held; n_len = r_len;
        n_kc = r_kc; n_ds = r_ds; n_eh = r_eh;
        bd = '0;
        restart = 1'b0;
        kind = cst_pkg::K_ID;
        hok = 1'b1;
        hv = 4'd0;
        if (b >= "0" && b <= "9") hv = 4'(b - "0");
        else if (b >= "a" && b <= "f") hv = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") hv = 4'(b - "A" + 8'd10);
        else hok = 1'b0;

        if (i_present && !n_eh) begin
            case (n_mode)
                cst_pkg::M_SLASH: begin
                    if (b == "/") n_mode = cst_pkg::M_COMMENT;
                    else begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_SLASH, 32'h0, 6'h0,
                                           cst_pkg::E_NONE);
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_COMMENT: if (b == "\n") n_mode = cst_pkg::M_IDLE;
                cst_pkg::M_ZERO, cst_pkg::M_DEC: begin
                    if (n_mode == cst_pkg::M_ZERO && (b == "x" || b == "X")) begin
                        n_mode = cst_pkg::M_HEX; n_acc = 32'h0; n_ds = 1'b0;
                    end else if (b >= "0" && b <= "9") begin
                        n_mode = cst_pkg::M_DEC;
                        n_acc = (n_acc << 3) + (n_acc << 1) + 32'(b - "0");
                    end else begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_INT, n_acc, 6'h0,
                                           cst_pkg::E_NONE);
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_HEX: begin
                    if (hok) begin
                        n_acc = {n_acc[27:0], hv}; n_ds = 1'b1;
                    end else if (n_ds) begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_INT, n_acc, 6'h0,
                                           cst_pkg::E_NONE);
                        restart = 1'b1;
                    end else begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                           cst_pkg::E_BAD_HEX);
                        n_eh = 1'b1; n_mode = cst_pkg::M_IDLE;
                    end
                end
                cst_pkg::M_STR, cst_pkg::M_STR_ESC: begin
                    if (n_mode == cst_pkg::M_STR_ESC && b == "n") begin
                        n_mode = cst_pkg::M_STR;
                        if (n_len < cst_pkg::LEN_W'(cst_pkg::TEXT_MAX)) begin
                            bd = cst_pkg::push(bd, 1'b1, "\n", cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                            n_len = n_len + 1'b1;
                        end
                    end else begin
                        if (n_mode == cst_pkg::M_STR_ESC) begin
                            n_mode = cst_pkg::M_STR;
                            if (n_len < cst_pkg::LEN_W'(cst_pkg::TEXT_MAX)) begin
                                bd = cst_pkg::push(bd, 1'b1, "\\", cst_pkg::K_EOF, 32'h0,
                                                   6'h0, cst_pkg::E_NONE);
                                n_len = n_len + 1'b1;
                            end
                        end
                        if (b == "\"") begin
                            bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_STRING, 32'h0,
                                               6'(n_len), cst_pkg::E_NONE);
                            n_mode = cst_pkg::M_IDLE;
                        end else if (b == "\\") begin
                            n_mode = cst_pkg::M_STR_ESC;
                        end else if (n_len < cst_pkg::LEN_W'(cst_pkg::TEXT_MAX)) begin
                            bd = cst_pkg::push(bd, 1'b1, b, cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                            n_len = n_len + 1'b1;
                        end
                    end
                end
                cst_pkg::M_CHR0: begin
                    if (b == "\\") n_mode = cst_pkg::M_CHR_ESC;
                    else begin
                        n_acc = {24'h0, b}; n_mode = cst_pkg::M_CHR_CLOSE;
                    end
                end
                cst_pkg::M_CHR_ESC: begin
                    if (b == "n") n_acc = 32'h0a;
                    else if (b == "t") n_acc = 32'h09;
                    else if (b == "0") n_acc = 32'h0;
                    else n_acc = {24'h0, b};
                    n_mode = cst_pkg::M_CHR_CLOSE;
                end
                cst_pkg::M_CHR_CLOSE: begin
                    if (b == "'") begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_INT,
                                           {{24{n_acc[7]}}, n_acc[7:0]}, 6'h0,
                                           cst_pkg::E_NONE);
                        n_mode = cst_pkg::M_IDLE;
                    end else begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                           cst_pkg::E_UNCLOSED);
                        n_eh = 1'b1; n_mode = cst_pkg::M_IDLE;
                    end
                end
                cst_pkg::M_IDENT: begin
                    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" ||
                        (b >= "0" && b <= "9")) begin
                        n_kc = cst_pkg::kw_mask(n_kc, n_len, b);
                        if (n_len < cst_pkg::LEN_W'(cst_pkg::TEXT_MAX)) begin
                            bd = cst_pkg::push(bd, 1'b1, b, cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                            n_len = n_len + 1'b1;
                        end
                    end else begin
                        for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
                            if (n_kc[k] && n_len == cst_pkg::LEN_W'(cst_pkg::kw_len(k)))
                                kind = cst_pkg::K_KW_BASE + 5'(k);
                        end
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'(n_len),
                                           cst_pkg::E_NONE);
                        restart = 1'b1;
                    end
                end
                cst_pkg::M_OPEQ: begin
                    if (b == "=") begin
                        n_mode = cst_pkg::M_IDLE;
                        if (n_held == "=") kind = cst_pkg::K_EQ;
                        else if (n_held == "!") kind = cst_pkg::K_NE;
                        else if (n_held == "<") kind = cst_pkg::K_LE;
                        else kind = cst_pkg::K_GE;
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'h0,
                                           cst_pkg::E_NONE);
                    end else begin
                        n_mode = cst_pkg::M_IDLE;
                        if (n_held == "=" || n_held == "<" || n_held == ">") begin
                            kind = (n_held == "=") ? cst_pkg::K_ASSIGN :
                                   (n_held == "<") ? cst_pkg::K_LT : cst_pkg::K_GT;
                            bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                        end else begin
                            bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_LONE_BANG);
                            n_eh = 1'b1;
                        end
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase
        end

        // start of a new token
        if (restart && !n_eh) begin
            n_mode = cst_pkg::M_IDLE;
            kind = cst_pkg::K_EOF;
            case (b)
                " ", "\n", "\t", 8'h0d: ;
                "/":  n_mode = cst_pkg::M_SLASH;
                "0":  begin n_mode = cst_pkg::M_ZERO; n_acc = 32'h0; end
                "\"": begin n_mode = cst_pkg::M_STR; n_len = '0; end
                "'":  begin n_mode = cst_pkg::M_CHR0; n_acc = 32'h0; end
                "+":  kind = cst_pkg::K_PLUS;
                "-":  kind = cst_pkg::K_MINUS;
                "*":  kind = cst_pkg::K_STAR;
                "(":  kind = cst_pkg::K_LPAREN;
                ")":  kind = cst_pkg::K_RPAREN;
                "[":  kind = cst_pkg::K_LBRACK;
                "]":  kind = cst_pkg::K_RBRACK;
                "{":  kind = cst_pkg::K_LBRACE;
                "}":  kind = cst_pkg::K_RBRACE;
                ";":  kind = cst_pkg::K_SEMI;
                ",":  kind = cst_pkg::K_COMMA;
                "=", "!", "<", ">": begin n_mode = cst_pkg::M_OPEQ; n_held = b; end
                default: begin
                    if (b >= "1" && b <= "9") begin
                        n_mode = cst_pkg::M_DEC; n_acc = 32'(b - "0");
                    end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                                 b == "_") begin
                        n_mode = cst_pkg::M_IDENT; n_len = '0;
                        n_kc = cst_pkg::kw_mask('1, '0, b);
                        bd = cst_pkg::push(bd, 1'b1, b, cst_pkg::K_EOF, 32'h0, 6'h0,
                                           cst_pkg::E_NONE);
                        n_len = cst_pkg::LEN_W'(1);
                    end else begin
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                           cst_pkg::E_UNKNOWN);
                        n_eh = 1'b1;
                    end
                end
            endcase
            if (kind != cst_pkg::K_EOF)
                bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'h0, cst_pkg::E_NONE);
        end

        // end of source
        if (i_eos) begin
            if (!n_eh) begin
                case (n_mode)
                    cst_pkg::M_SLASH:
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_SLASH, 32'h0, 6'h0,
                                           cst_pkg::E_NONE);
                    cst_pkg::M_ZERO, cst_pkg::M_DEC:
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_INT, n_acc, 6'h0,
                                           cst_pkg::E_NONE);
                    cst_pkg::M_HEX:
                        if (n_ds) bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_INT, n_acc,
                                                     6'h0, cst_pkg::E_NONE);
                        else bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                                cst_pkg::E_BAD_HEX);
                    cst_pkg::M_STR, cst_pkg::M_STR_ESC: begin
                        if (n_mode == cst_pkg::M_STR_ESC &&
                            n_len < cst_pkg::LEN_W'(cst_pkg::TEXT_MAX)) begin
                            bd = cst_pkg::push(bd, 1'b1, "\\", cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                            n_len = n_len + 1'b1;
                        end
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_STRING, 32'h0,
                                           6'(n_len), cst_pkg::E_NONE);
                    end
                    cst_pkg::M_CHR0, cst_pkg::M_CHR_ESC, cst_pkg::M_CHR_CLOSE:
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                           cst_pkg::E_UNCLOSED);
                    cst_pkg::M_IDENT: begin
                        kind = cst_pkg::K_ID;
                        for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
                            if (n_kc[k] && n_len == cst_pkg::LEN_W'(cst_pkg::kw_len(k)))
                                kind = cst_pkg::K_KW_BASE + 5'(k);
                        end
                        bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'(n_len),
                                           cst_pkg::E_NONE);
                    end
                    cst_pkg::M_OPEQ: begin
                        if (n_held == "=" || n_held == "<" || n_held == ">") begin
                            kind = (n_held == "=") ? cst_pkg::K_ASSIGN :
                                   (n_held == "<") ? cst_pkg::K_LT : cst_pkg::K_GT;
                            bd = cst_pkg::push(bd, 1'b0, 8'h0, kind, 32'h0, 6'h0,
                                               cst_pkg::E_NONE);
                        end else
                            bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0,
                                               cst_pkg::E_LONE_BANG);
                    end
                    default: ;
                endcase
            end
            bd = cst_pkg::push(bd, 1'b0, 8'h0, cst_pkg::K_EOF, 32'h0, 6'h0, cst_pkg::E_NONE);
            n_mode = cst_pkg::M_IDLE; n_acc = 32'h0; n_held = 8'h0; n_len = '0;
            n_kc = '1; n_ds = 1'b0; n_eh = 1'b0;
        end
    end

    assign o_bundle = bd;
    assign o_push   = i_accept && (bd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cst_pkg::M_IDLE;
            r_acc  <= 32'h0;
            r_held <= 8'h0;
            r_len  <= '0;
            r_kc   <= '1;
            r_ds   <= 1'b0;
            r_eh   <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_held <= n_held;
            r_len  <= n_len;
            r_kc   <= n_kc;
            r_ds   <= n_ds;
            r_eh   <= n_eh;
        end
    end
endmodule
`default_nettype wire

/* sv/cst_fifo.sv */
// cst_fifo: short queue of result bundles between scanner and output stage
// depends on cst_pkg
`default_nettype none
module cst_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  cst_pkg::t_bundle       i_bundle,
    input  wire logic              i_pop,
    output cst_pkg::t_bundle       o_head,
    output cst_pkg::t_qstat        o_stat
);
    localparam int PW = $clog2(cst_pkg::QDEPTH);
    cst_pkg::t_bundle              r_mem [cst_pkg::QDEPTH];
    logic [PW-1:0]                 r_wp, r_rp;
    logic [PW:0]                   r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(cst_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* sv/cst_back.sv */
// cst_back: walks the head bundle and sends its results one at a time
// depends on cst_pkg
`default_nettype none
module cst_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  cst_pkg::t_bundle       i_head,
    input  cst_pkg::t_qstat        i_stat,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output cst_pkg::t_res          o_res,
    output logic                   o_last,
    output logic                   o_pop
);
    logic [1:0] r_idx;

    assign o_tvalid = !i_stat.empty;
    assign o_res    = i_head.res[r_idx];
    assign o_last   = ({1'b0, r_idx} == i_head.cnt - 3'd1);
    assign o_pop    = o_tvalid && i_tready && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_idx <= 2'd0;
        else if (o_pop) r_idx <= 2'd0;
        else if (o_tvalid && i_tready) r_idx <= r_idx + 2'd1;
    end
endmodule
`default_nettype wire

/* sv/c_subset_tokenizer.sv */
// c_subset_tokenizer: top level of the c-subset lexer
// depends on cst_pkg, cst_front, cst_fifo, cst_back
//
// slave stream: one source byte per request, tdata[7:0] source_byte,
//   tuser byte_present, tlast end_of_source
// master stream: one result per request, tuser is_text, tlast last_of_run
// the scanner takes a request in every cycle the bundle queue has room and
// turns it into zero to four results in that same cycle
// first result of a request shows from the bundle queue once the bundles ahead of it are sent
// throughput: one request per cycle while the queue has room; a request with n results
//   sends them one at a time, so bursts of multi-result requests fill the four-entry
//   queue and then hold s_tready low
// reset: scanner returns to idle, queue and output are emptied
// receiver stall: results wait in the queue, input keeps flowing until the
//   queue is full
`default_nettype none
module c_subset_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // source_byte
    input  wire logic        s_tuser,   // byte_present
    input  wire logic        s_tlast,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // text_char, token_kind, token_value, text_length,
                                        // error_code, zero pad
    output logic             m_tuser,   // is_text
    output logic             m_tlast    // last_of_run
);
    cst_pkg::t_bundle  front_bd, head;
    cst_pkg::t_qstat   qstat;
    cst_pkg::t_res     res;
    logic              push, pop, accept;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    cst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept), .i_byte(s_tdata),
        .i_present(s_tuser), .i_eos(s_tlast), .o_bundle(front_bd), .o_push(push)
    );

    cst_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_bundle(front_bd),
        .i_pop(pop), .o_head(head), .o_stat(qstat)
    );

    cst_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .i_stat(qstat),
        .i_tready(m_tready), .o_tvalid(m_tvalid), .o_res(res), .o_last(m_tlast),
        .o_pop(pop)
    );

    assign m_tuser = res.is_text;
    assign m_tdata = {2'b00, res.error_code, res.text_length, res.token_value,
                      res.token_kind, res.text_char};
endmodule
`default_nettype wire

/* sv/cst_checker.sv */
// cst_checker: port-level assertions for c_subset_tokenizer, bound to the top level
// depends on c_subset_tokenizer ports only
`default_nettype none
module cst_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid) else $error("output valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_text_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata[53:8] == 46'd0)
        else $error("text result carries record fields");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[53:51] != 3'd0 |-> !m_tuser && m_tdata[12:8] == 5'd0)
        else $error("error result carries a kind");
endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
